### sv/cookie_value_extractor_assert.svh
// Assertion macros shared by the cookie value extractor RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef COOKIE_VALUE_EXTRACTOR_ASSERT_SVH
`define COOKIE_VALUE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define CVE_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high
`define CVE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/cve_pkg.sv
// Package for the cookie value extractor: widths, register indexes,
// character codes and the types passed between its modules. No dependencies.
`default_nettype none

package cve_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NAME_LEN_W = 6;
  localparam int CAP_W      = 9;
  localparam int CAP_MAX    = 256;
  localparam int NAME_REG_BYTES = 8;

  localparam int DEF_MAX_NAME_BYTES = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BYTES_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BYTES_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BYTES_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BYTES_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 3'd5;

  // Character codes
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Clamped settings seen by the scanner
  typedef struct packed {
    logic [NAME_LEN_W-1:0] name_count;
    logic [CAP_W-1:0]      capacity;
  } scan_cfg_t;

  // One result beat
  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_byte;
    logic       done_res;
    logic       found;
  } result_t;

endpackage

`default_nettype wire

### sv/cve_if.sv
// Stream interfaces of the cookie value extractor: text bytes in, results out.
// Depends on nothing.
`default_nettype none

interface cve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface cve_out_if;
  logic       valid;
  logic       ready;
  logic       value_valid;
  logic [7:0] value_byte;
  logic       done_res;
  logic       found;

  modport source (output valid, output value_valid, output value_byte,
                  output done_res, output found, input ready);
  modport sink   (input valid, input value_valid, input value_byte,
                  input done_res, input found, output ready);
endinterface

`default_nettype wire

### sv/cve_cfg.sv
// Configuration registers: search name bytes, name length, output capacity.
// Depends on cve_pkg.
`default_nettype none

module cve_cfg
  import cve_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  output logic [MAX_NAME_BYTES-1:0][7:0] name_bytes,
  output scan_cfg_t                  scan_cfg
);

  logic [NAME_LEN_W-1:0] name_length;
  logic [CAP_W-1:0]      output_capacity;

  // Name bytes: byte b lives in register b/8, lane b%8
  for (genvar b = 0; b < MAX_NAME_BYTES; b++) begin : g_name
    localparam int RegSel = b / NAME_REG_BYTES;
    localparam int Lane   = b % NAME_REG_BYTES;
    always_ff @(posedge clk) begin
      if (rst) begin
        name_bytes[b] <= '0;
      end else if (cfg_wr_en &&
                   cfg_index == REG_NAME_BYTES_0 + CFG_IDX_W'(RegSel)) begin
        name_bytes[b] <= cfg_wr_data[Lane*8 +: 8];
      end
    end
  end

  // Length and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      name_length     <= '0;
      output_capacity <= CAP_W'(CAP_MAX);
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_NAME_LENGTH) begin
        name_length <= cfg_wr_data[NAME_LEN_W-1:0];
      end
      if (cfg_index == REG_OUTPUT_CAPACITY) begin
        output_capacity <= cfg_wr_data[CAP_W-1:0];
      end
    end
  end

  // Clamp to the supported ranges
  always_comb begin
    scan_cfg.name_count = (name_length > NAME_LEN_W'(MAX_NAME_BYTES)) ?
                          NAME_LEN_W'(MAX_NAME_BYTES) : name_length;
    scan_cfg.capacity = (output_capacity > CAP_W'(CAP_MAX)) ?
                        CAP_W'(CAP_MAX) : output_capacity;
  end

endmodule

`default_nettype wire

### sv/cve_scan.sv
// Cookie scanner: mode, name index and value count, with the result register.
// Depends on cve_pkg.
`default_nettype none

module cve_scan
  import cve_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [MAX_NAME_BYTES-1:0][7:0] name_bytes,
  input  wire scan_cfg_t                     scan_cfg,
  input  wire logic                          beat_valid,
  input  wire logic [7:0]                    beat_char,
  input  wire logic                          beat_eot,
  output logic                               consume,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output result_t                            res
);

  localparam int NIDX_W = $clog2(MAX_NAME_BYTES + 1);
  localparam int IDX_W  = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

  typedef enum logic [2:0] {
    MODE_SKIPWS,
    MODE_NAME,
    MODE_SKIPSEMI,
    MODE_VALUE,
    MODE_DONE
  } mode_t;

  mode_t             mode, mode_next;
  logic [NIDX_W-1:0] name_index, name_index_next;
  logic [7:0]        value_count, value_count_next;
  result_t           res_next;

  logic [NIDX_W-1:0] name_end;
  logic [NIDX_W-1:0] cmp_idx;
  logic [7:0]        want_byte;
  logic              is_blank, is_semi, name_full, cmp_hit, start_value;

  assign consume = beat_valid && (!res_valid || res_ready);

  // Name compare against the current name position
  always_comb begin
    name_end    = NIDX_W'(scan_cfg.name_count);
    cmp_idx     = (mode == MODE_NAME) ? name_index : '0;
    want_byte   = name_bytes[cmp_idx[IDX_W-1:0]];
    is_blank    = (beat_char == CH_SPACE) || (beat_char == CH_TAB);
    is_semi     = (beat_char == CH_SEMI);
    name_full   = (cmp_idx >= name_end);
    start_value = name_full && (beat_char == CH_EQUAL) && (scan_cfg.capacity != '0);
    cmp_hit     = !name_full && (beat_char == want_byte);
  end

  // Next state and result
  always_comb begin
    mode_next        = mode;
    name_index_next  = name_index;
    value_count_next = value_count;
    res_next         = '0;
    if (beat_eot) begin
      if (mode != MODE_DONE) begin
        res_next.done_res = 1'b1;
        res_next.found    = (mode == MODE_VALUE);
      end
      mode_next        = MODE_SKIPWS;
      name_index_next  = '0;
      value_count_next = '0;
    end else begin
      unique case (mode) inside
        MODE_SKIPWS, MODE_NAME: begin
          if (mode == MODE_NAME || !is_blank) begin
            if (start_value) begin
              mode_next        = MODE_VALUE;
              value_count_next = '0;
              name_index_next  = '0;
            end else if (cmp_hit) begin
              mode_next       = MODE_NAME;
              name_index_next = cmp_idx + NIDX_W'(1);
            end else begin
              mode_next       = is_semi ? MODE_SKIPWS : MODE_SKIPSEMI;
              name_index_next = '0;
            end
          end
        end
        MODE_SKIPSEMI: begin
          if (is_semi) mode_next = MODE_SKIPWS;
        end
        MODE_VALUE: begin
          if (is_semi) begin
            res_next.done_res = 1'b1;
            res_next.found    = 1'b1;
            mode_next         = MODE_DONE;
          end else if ({1'b0, value_count} + CAP_W'(1) < scan_cfg.capacity) begin
            res_next.value_valid = 1'b1;
            res_next.value_byte  = beat_char;
            value_count_next     = value_count + 8'd1;
          end
        end
        MODE_DONE: begin
        end
        default: begin
          mode_next       = MODE_SKIPWS;
          name_index_next = '0;
        end
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SKIPWS;
      name_index  <= '0;
      value_count <= '0;
      res_valid   <= 1'b0;
    end else if (consume) begin
      mode        <= mode_next;
      name_index  <= name_index_next;
      value_count <= value_count_next;
      res_valid   <= 1'b1;
      res         <= res_next;
    end else if (res_ready) begin
      res_valid   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/cookie_value_extractor.sv
// Top level of the cookie value extractor: input register, config, scanner.
// Depends on cve_pkg, cve_if, cve_cfg, cve_scan and the assertion header.
//
//   channel   dir  handshake        beat
//   in_ch     in   valid / ready    char_byte, end_of_text
//   out_ch    out  valid / ready    value_valid, value_byte, done_res, found
//   cfg       in   cfg_wr_en only   cfg_index, cfg_wr_data
//
// One text byte per cycle sustained while out_ch is ready; every beat gives exactly one result beat.
// Path: an input register, then the scan and result register.
// The input register takes one more beat while a result waits on out_ch.
// Synchronous reset clears scan state, configuration and both valid flags.
`default_nettype none
`include "cookie_value_extractor_assert.svh"

module cookie_value_extractor
  import cve_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  cve_in_if.sink                     in_ch,
  cve_out_if.source                  out_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  logic [MAX_NAME_BYTES-1:0][7:0] name_bytes;
  scan_cfg_t scan_cfg;

  logic       in_q_valid;
  logic [7:0] in_q_char;
  logic       in_q_eot;
  logic       consume;
  logic       res_valid;
  result_t    res;

  // Input register
  assign in_ch.ready = !in_q_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_q_valid <= 1'b1;
      in_q_char  <= in_ch.char_byte;
      in_q_eot   <= in_ch.end_of_text;
    end else if (consume) begin
      in_q_valid <= 1'b0;
    end
  end

  cve_cfg #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .name_bytes  (name_bytes),
    .scan_cfg    (scan_cfg)
  );

  cve_scan #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .name_bytes (name_bytes),
    .scan_cfg   (scan_cfg),
    .beat_valid (in_q_valid),
    .beat_char  (in_q_char),
    .beat_eot   (in_q_eot),
    .consume    (consume),
    .res_valid  (res_valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  // Result channel
  assign out_ch.valid       = res_valid;
  assign out_ch.value_valid = res.value_valid;
  assign out_ch.value_byte  = res.value_byte;
  assign out_ch.done_res    = res.done_res;
  assign out_ch.found       = res.found;

  // Checks
  `CVE_ASSERT_IMPLY(a_found_with_done, out_ch.valid && out_ch.found,
                    out_ch.done_res, "found raised without done")
  `CVE_ASSERT_IMPLY(a_done_no_byte, out_ch.valid && out_ch.done_res,
                    !out_ch.value_valid, "value byte on the done beat")
  `CVE_ASSERT_IMPLY(a_full_accept, in_ch.valid && in_ch.ready && in_q_valid,
                    consume, "beat accepted over a held input")
  `CVE_ASSERT_NEXT(a_held_input, in_q_valid && !consume,
                   in_q_valid, "held input beat dropped")

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for cookie_value_extractor: directed table, then
// randomised cookie headers under several register settings.
// Depends on cve_pkg, the cve_in_if / cve_out_if interfaces and the RTL.
`default_nettype none

module tb_top;
  import cve_pkg::*;

  localparam int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASES         = 10;
  localparam int PHASE_BEATS    = 140;

  // Scanner modes tracked by the predictor
  typedef enum logic [2:0] {
    SCAN_SKIP_WS,
    SCAN_NAME,
    SCAN_SKIP_SEMI,
    SCAN_VALUE,
    SCAN_DONE
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  // Directed row: typed marks a hand-written expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  // Search name "ab", capacity 3: at most two value bytes
  localparam dir_row_t DIRECTED [0:24] = '{
    '{8'h00,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}}, // end of empty text
    '{CH_SPACE, 1'b0, 1'b0, NO_RESULT},                  // leading blanks
    '{CH_TAB,   1'b0, 1'b0, NO_RESULT},
    '{"a",      1'b0, 1'b0, NO_RESULT},
    '{"x",      1'b0, 1'b0, NO_RESULT},                  // mismatch, skip to ';'
    '{8'hFF,    1'b0, 1'b0, NO_RESULT},
    '{CH_SEMI,  1'b0, 1'b0, NO_RESULT},
    '{"a",      1'b0, 1'b0, NO_RESULT},
    '{CH_SEMI,  1'b0, 1'b0, NO_RESULT},                  // mismatch on separator
    '{"a",      1'b0, 1'b0, NO_RESULT},
    '{"b",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQUAL, 1'b0, 1'b0, NO_RESULT},
    '{8'h00,    1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}}, // zero byte is data
    '{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
    '{"z",      1'b0, 1'b1, NO_RESULT},                  // truncated
    '{CH_SEMI,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}}, // found, then separator
    '{"a",      1'b0, 1'b0, NO_RESULT},                  // ignored after done
    '{8'h00,    1'b1, 1'b1, NO_RESULT},                  // end after done: no flags
    '{"a",      1'b0, 1'b0, NO_RESULT},
    '{"b",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQUAL, 1'b0, 1'b0, NO_RESULT},
    '{"q",      1'b0, 1'b1, '{1'b1, "q", 1'b0, 1'b0}},
    '{8'hFF,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}}, // end while in value
    '{"a",      1'b0, 1'b0, NO_RESULT},
    '{8'h5A,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}}  // end while in name
  };

  logic clk;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  cve_in_if  in_ch ();
  cve_out_if out_ch ();

  cookie_value_extractor dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state and its copy of the registers
  scan_mode_e  m_mode;
  logic [5:0]  m_idx;
  logic [7:0]  m_count;
  logic [63:0] m_name [4];
  logic [5:0]  m_len;
  logic [8:0]  m_cap;

  result_t    result_q [$];
  text_beat_t text_q [$];

  bit steady;
  int err_count;
  int cycles;
  int stall_left;
  int beats_sent;
  int beats_checked;
  int texts_sent;
  int value_seen;
  int found_seen;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_name_len();
    return (m_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(m_len);
  endfunction

  function automatic int eff_capacity();
    return (m_cap > CAP_MAX) ? CAP_MAX : int'(m_cap);
  endfunction

  function automatic logic [7:0] name_char(input int k);
    return m_name[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void drop_segment(input logic [7:0] ch);
    if (ch == CH_SEMI) begin
      m_mode = SCAN_SKIP_WS;
    end else begin
      m_mode = SCAN_SKIP_SEMI;
    end
    m_idx = '0;
  endfunction

  function automatic void compare_name_byte(input logic [7:0] ch);
    if (m_idx >= eff_name_len()) begin
      if (ch == CH_EQUAL && eff_capacity() != 0) begin
        m_mode  = SCAN_VALUE;
        m_count = '0;
        m_idx   = '0;
      end else begin
        drop_segment(ch);
      end
    end else if (ch == name_char(int'(m_idx))) begin
      m_idx = m_idx + 6'd1;
    end else begin
      drop_segment(ch);
    end
  endfunction

  function automatic result_t predict_beat(input logic [7:0] ch, input logic eot);
    result_t r;
    r = '0;
    if (eot) begin
      if (m_mode != SCAN_DONE) begin
        r.done_res = 1'b1;
        r.found    = (m_mode == SCAN_VALUE);
      end
      m_mode  = SCAN_SKIP_WS;
      m_idx   = '0;
      m_count = '0;
    end else begin
      case (m_mode)
        SCAN_SKIP_WS: begin
          if (ch != CH_SPACE && ch != CH_TAB) begin
            m_mode = SCAN_NAME;
            m_idx  = '0;
            compare_name_byte(ch);
          end
        end
        SCAN_NAME: begin
          compare_name_byte(ch);
        end
        SCAN_SKIP_SEMI: begin
          if (ch == CH_SEMI) m_mode = SCAN_SKIP_WS;
        end
        SCAN_VALUE: begin
          if (ch == CH_SEMI) begin
            r.done_res = 1'b1;
            r.found    = 1'b1;
            m_mode     = SCAN_DONE;
          end else if (int'(m_count) + 1 < eff_capacity()) begin
            r.value_valid = 1'b1;
            r.value_byte  = ch;
            m_count       = m_count + 8'd1;
          end
        end
        default: begin
          // done: everything up to end of text is ignored
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SEMI);
    return b;
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    text_q.push_back('{ch, 1'b0});
  endfunction

  // One header: up to four segments, about half well formed, the rest broken, then end
  function automatic void build_text();
    int nseg, kind, n, vlen, len;
    logic [7:0] b;
    len  = eff_name_len();
    nseg = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      n = $urandom_range(0, 2);
      for (int w = 0; w < n; w++) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // full name, '=', value
        for (int k = 0; k < len; k++) push_char(name_char(k));
        push_char(CH_EQUAL);
        vlen = ($urandom_range(0, 19) == 0) ? eff_capacity() + 1 : $urandom_range(0, 5);
        for (int k = 0; k < vlen; k++) push_char(plain_byte());
      end else if (kind < 7) begin
        // partial name, then any byte
        n = (len > 0) ? $urandom_range(0, len - 1) : 0;
        for (int k = 0; k < n; k++) push_char(name_char(k));
        push_char(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) push_char(plain_byte());
      end else if (kind == 7) begin
        // full name not followed by '='
        for (int k = 0; k < len; k++) push_char(name_char(k));
        do b = 8'($urandom_range(0, 255)); while (b == CH_EQUAL);
        push_char(b);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) push_char(plain_byte());
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) push_char(8'($urandom_range(0, 255)));
      end
      if (s < nseg - 1 || $urandom_range(0, 2) == 0) push_char(CH_SEMI);
    end
    text_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic eot,
                           input bit typed, input result_t typed_res);
    int gap;
    result_t pred;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_byte   <= ch;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_beat(ch, eot);
    result_q.push_back(typed ? typed_res : pred);
    beats_sent++;
    if (eot) texts_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_NAME_BYTES_0:    m_name[0] = data;
      REG_NAME_BYTES_1:    m_name[1] = data;
      REG_NAME_BYTES_2:    m_name[2] = data;
      REG_NAME_BYTES_3:    m_name[3] = data;
      REG_NAME_LENGTH:     m_len     = data[NAME_LEN_W-1:0];
      REG_OUTPUT_CAPACITY: m_cap     = data[CAP_W-1:0];
      default: ;
    endcase
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // New register setting: random name bytes, no ';' inside the name
  task automatic load_setting(input int phase);
    logic [63:0] regs [4];
    int len, cap, used;
    logic [7:0] b;
    case (phase)
      0:       begin len = 0;  cap = 5;   end
      1:       begin len = 32; cap = 256; end
      2:       begin len = 45; cap = 511; end
      3:       begin len = 3;  cap = 0;   end
      4:       begin len = 2;  cap = 1;   end
      5:       begin len = 1;  cap = 2;   end
      6:       begin len = 63; cap = 257; end
      default: begin
        len = $urandom_range(1, 8);
        cap = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 511);
      end
    endcase
    used = (len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : len;
    for (int r = 0; r < 4; r++) regs[r] = {$urandom(), $urandom()};
    for (int k = 0; k < used; k++) begin
      b = ($urandom_range(0, 9) < 7) ? 8'("a" + $urandom_range(0, 25)) : plain_byte();
      regs[k / 8][(k % 8) * 8 +: 8] = b;
    end
    write_reg(REG_NAME_BYTES_0, regs[0]);
    write_reg(REG_NAME_BYTES_1, regs[1]);
    write_reg(REG_NAME_BYTES_2, regs[2]);
    write_reg(REG_NAME_BYTES_3, regs[3]);
    write_reg(REG_NAME_LENGTH, 64'(len));
    write_reg(REG_OUTPUT_CAPACITY, 64'(cap));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic log_error(input string what, input result_t want, input result_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR %s: want vv=%0b vb=%02h done=%0b found=%0b, got vv=%0b vb=%02h done=%0b found=%0b",
               what, want.value_valid, want.value_byte, want.done_res, want.found,
               got.value_valid, got.value_byte, got.done_res, got.found);
    end
  endtask

  // Result side: compare each beat and stall ready at random
  always @(posedge clk) begin : result_side
    result_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.value_valid, out_ch.value_byte, out_ch.done_res, out_ch.found};
        beats_checked++;
        if (got.value_valid === 1'b1) value_seen++;
        if (got.found === 1'b1) found_seen++;
        if (result_q.size() == 0) begin
          log_error("unexpected beat", NO_RESULT, got);
        end else begin
          want = result_q.pop_front();
          if (got.value_valid !== want.value_valid || got.value_byte !== want.value_byte ||
              got.done_res !== want.done_res || got.found !== want.found) begin
            log_error("result mismatch", want, got);
          end
        end
      end
      if (steady) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    text_beat_t tb_beat;
    int phase_beats;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= '0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.char_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // state after reset
    m_mode  = SCAN_SKIP_WS;
    m_idx   = '0;
    m_count = '0;
    for (int r = 0; r < 4; r++) m_name[r] = '0;
    m_len = '0;
    m_cap = 9'(CAP_MAX);

    // Directed table
    write_reg(REG_NAME_BYTES_0, 64'h6261);
    write_reg(REG_NAME_LENGTH, 64'd2);
    write_reg(REG_OUTPUT_CAPACITY, 64'd3);
    cfg_wr_en <= 1'b0;
    settings_used++;
    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random headers, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      drain();
      load_setting(p);
      steady = (p % 4 == 3);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        build_text();
        while (text_q.size() != 0) begin
          tb_beat = text_q.pop_front();
          send_beat(tb_beat.ch, tb_beat.eot, 1'b0, NO_RESULT);
          phase_beats++;
        end
      end
    end
    steady = 1'b0;
    drain();

    $display("Sent %0d beats in %0d texts over %0d register settings; checked %0d results",
             beats_sent, texts_sent, settings_used, beats_checked);
    $display("Value bytes seen: %0d, found flags seen: %0d", value_seen, found_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors in total", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
